>>> hw/rtl/rdh_pkg.sv
// Package with the sizes, codes, command type and helper functions of the histogram engine.
package rdh_pkg;

	localparam int RELEASES  = 64;
	localparam int GRID      = 64;
	localparam int MONTHS    = 32;
	localparam int DIST_BINS = 64;

	localparam int REL_AW    = 6;
	localparam int BIN_AW    = 12;
	localparam int DIST_AW   = 11;
	localparam int HIST_AW   = 12;
	localparam int REL_W     = 44;

	localparam logic [2:0] OP_CLEAR   = 3'd0;
	localparam logic [2:0] OP_RELEASE = 3'd1;
	localparam logic [2:0] OP_BIN     = 3'd2;
	localparam logic [2:0] OP_RECAP   = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;
	localparam logic [2:0] OP_NOP     = 3'd7;

	localparam logic [1:0] SEL_DIST = 2'd0;
	localparam logic [1:0] SEL_X    = 2'd1;
	localparam logic [1:0] SEL_Y    = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [1:0] STAT_NEGTIME  = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  slot;
		logic [15:0] cohort_id;
		logic [15:0] date_months;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic [15:0] weight;
		logic [5:0]  bin_value;
		logic [1:0]  table_select;
		logic [4:0]  read_month;
		logic [6:0]  read_index;
		logic        read_ok;
	} cmd_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] w);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, w};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

>>> hw/rtl/rdh_front.sv
// Front end: accepts input items and classifies them into commands for the queue.
module rdh_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       operation,
	input  logic [5:0]       slot,
	input  logic [15:0]      cohort_id,
	input  logic [15:0]      date_months,
	input  logic [5:0]       cell_x,
	input  logic [5:0]       cell_y,
	input  logic [15:0]      weight,
	input  logic [5:0]       bin_value,
	input  logic [1:0]       table_select,
	input  logic [4:0]       read_month,
	input  logic [6:0]       read_index,
	input  logic             q_full,
	output logic             q_push,
	output rdh_pkg::cmd_t    q_cmd
);
	import rdh_pkg::*;

	logic idx_ok;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		unique case (table_select)
			SEL_DIST: idx_ok = {1'b0, read_index} < 8'(DIST_BINS);
			SEL_X:    idx_ok = {1'b0, read_index} < 8'(2 * GRID - 1);
			SEL_Y:    idx_ok = {1'b0, read_index} < 8'(2 * GRID - 1);
			default:  idx_ok = 1'b0;
		endcase
	end

	always_comb begin
		q_cmd.slot         = slot;
		q_cmd.cohort_id    = cohort_id;
		q_cmd.date_months  = date_months;
		q_cmd.cell_x       = cell_x;
		q_cmd.cell_y       = cell_y;
		q_cmd.weight       = weight;
		q_cmd.bin_value    = bin_value;
		q_cmd.table_select = table_select;
		q_cmd.read_month   = read_month;
		q_cmd.read_index   = read_index;
		q_cmd.read_ok      = idx_ok && ({3'd0, read_month} < 8'(MONTHS));
		unique case (operation)
			OP_CLEAR:   q_cmd.kind = OP_CLEAR;
			OP_RELEASE: q_cmd.kind = ({2'd0, slot} < 8'(RELEASES)) ? OP_RELEASE : OP_NOP;
			OP_BIN:     q_cmd.kind = (({2'd0, cell_x} < 8'(GRID)) && ({2'd0, cell_y} < 8'(GRID)))
				? OP_BIN : OP_NOP;
			OP_RECAP:   q_cmd.kind = OP_RECAP;
			OP_READ:    q_cmd.kind = OP_READ;
			default:    q_cmd.kind = OP_NOP;
		endcase
	end

endmodule

>>> hw/rtl/rdh_queue.sv
// Two-entry command queue between the front end and the execution back end.
module rdh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rdh_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output rdh_pkg::cmd_t head_cmd
);
	import rdh_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full     = fill_q == 2'd2;
	assign empty    = fill_q == 2'd0;
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

>>> hw/rtl/rdh_back.sv
// Back end: release search, histogram updates, clearing sweeps, reads and the result register.
module rdh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [6:0]    cfg_wdata,
	input  logic          q_empty,
	input  rdh_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    status,
	output logic [31:0]   count
);
	import rdh_pkg::*;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_SRCH = 4'd2;
	localparam logic [3:0] ST_CALC = 4'd3;
	localparam logic [3:0] ST_RD1  = 4'd4;
	localparam logic [3:0] ST_RD2  = 4'd5;
	localparam logic [3:0] ST_RD3  = 4'd6;
	localparam logic [3:0] ST_FIN  = 4'd7;

	logic [REL_W-1:0] rel_mem  [RELEASES];
	logic [5:0]       bin_mem  [GRID*GRID];
	logic [31:0]      dist_mem [2**DIST_AW];
	logic [31:0]      x_mem    [2**HIST_AW];
	logic [31:0]      y_mem    [2**HIST_AW];

	logic [3:0]         state_q;
	cmd_t               cmd_q;
	logic [HIST_AW-1:0] cnt_q;
	logic               chk_q;
	logic               emit_q;
	logic [6:0]         active_q;
	logic [4:0]         row_q;
	logic [6:0]         dxi_q;
	logic [6:0]         dyi_q;
	logic [BIN_AW-1:0]  bin_addr_q;
	logic [DIST_AW-1:0] d_addr_q;
	logic [1:0]         res_status_q;
	logic [31:0]        res_count_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [31:0]        count_q;

	logic [REL_W-1:0]   rel_rd_q;
	logic [5:0]         bin_rd_q;
	logic [31:0]        d_rd_q;
	logic [31:0]        x_rd_q;
	logic [31:0]        y_rd_q;

	logic               rel_we, rel_re, bin_we, bin_re;
	logic               d_we, d_re, x_we, x_re, y_we, y_re;
	logic [REL_AW-1:0]  rel_addr;
	logic [BIN_AW-1:0]  bin_addr;
	logic [DIST_AW-1:0] d_addr;
	logic [HIST_AW-1:0] x_addr;
	logic [HIST_AW-1:0] y_addr;
	logic [31:0]        d_wdata, x_wdata, y_wdata;

	logic [6:0]         n_search;
	logic               match;
	logic               out_free;
	logic [16:0]        tal;
	logic [4:0]         row_c;
	logic signed [7:0]  dx_raw, dy_raw, dx_c, dy_c;
	logic [5:0]         ax, ay;
	logic [5:0]         bin_k;
	logic [31:0]        read_val;

	assign n_search = (active_q > 7'(RELEASES)) ? 7'(RELEASES) : active_q;
	assign match    = rel_rd_q[43:28] == cmd_q.cohort_id;
	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign count     = count_q;

	always_comb begin
		tal    = {1'b0, cmd_q.date_months} - {1'b0, rel_rd_q[27:12]};
		row_c  = tal[16] ? 5'd0 : ((tal[15:0] > 16'(MONTHS - 1)) ? 5'(MONTHS - 1) : tal[4:0]);
		dx_raw = $signed({2'b00, cmd_q.cell_x}) - $signed({2'b00, rel_rd_q[5:0]});
		dy_raw = $signed({2'b00, cmd_q.cell_y}) - $signed({2'b00, rel_rd_q[11:6]});
		dx_c   = (dx_raw > $signed(8'(GRID - 1))) ? $signed(8'(GRID - 1)) :
			(dx_raw < -$signed(8'(GRID - 1))) ? -$signed(8'(GRID - 1)) : dx_raw;
		dy_c   = (dy_raw > $signed(8'(GRID - 1))) ? $signed(8'(GRID - 1)) :
			(dy_raw < -$signed(8'(GRID - 1))) ? -$signed(8'(GRID - 1)) : dy_raw;
		ax     = dx_c[7] ? 6'(-dx_c) : dx_c[5:0];
		ay     = dy_c[7] ? 6'(-dy_c) : dy_c[5:0];
		bin_k  = ({1'b0, bin_rd_q} > 7'(DIST_BINS - 1)) ? 6'(DIST_BINS - 1) : bin_rd_q;
		case (cmd_q.table_select)
			SEL_DIST: read_val = d_rd_q;
			SEL_X:    read_val = x_rd_q;
			default:  read_val = y_rd_q;
		endcase
	end

	always_comb begin
		rel_we   = 1'b0;
		rel_re   = 1'b0;
		bin_we   = 1'b0;
		bin_re   = 1'b0;
		d_we     = 1'b0;
		d_re     = 1'b0;
		x_we     = 1'b0;
		x_re     = 1'b0;
		y_we     = 1'b0;
		y_re     = 1'b0;
		rel_addr = cnt_q[REL_AW-1:0];
		bin_addr = bin_addr_q;
		d_addr   = {row_q, bin_k};
		x_addr   = {row_q, dxi_q};
		y_addr   = {row_q, dyi_q};
		d_wdata  = sat_add(d_rd_q, cmd_q.weight);
		x_wdata  = sat_add(x_rd_q, cmd_q.weight);
		y_wdata  = sat_add(y_rd_q, cmd_q.weight);
		unique case (state_q)
			ST_CLR: begin
				d_we    = 1'b1;
				x_we    = 1'b1;
				y_we    = 1'b1;
				d_addr  = cnt_q[DIST_AW-1:0];
				x_addr  = cnt_q;
				y_addr  = cnt_q;
				d_wdata = 32'd0;
				x_wdata = 32'd0;
				y_wdata = 32'd0;
			end
			ST_IDLE: begin
				rel_addr = q_cmd.slot;
				bin_addr = {q_cmd.cell_x, q_cmd.cell_y};
				rel_we   = q_pop && (q_cmd.kind == OP_RELEASE);
				bin_we   = q_pop && (q_cmd.kind == OP_BIN);
			end
			ST_SRCH: begin
				rel_re = !(chk_q && match) && (cnt_q[6:0] != n_search);
			end
			ST_RD1: begin
				if (cmd_q.kind == OP_READ) begin
					d_addr = {cmd_q.read_month, cmd_q.read_index[5:0]};
					x_addr = {cmd_q.read_month, cmd_q.read_index};
					y_addr = {cmd_q.read_month, cmd_q.read_index};
				end
				bin_re = cmd_q.kind != OP_READ;
				d_re   = cmd_q.kind == OP_READ;
				x_re   = 1'b1;
				y_re   = 1'b1;
			end
			ST_RD2: begin
				x_we = cmd_q.kind != OP_READ;
				y_we = cmd_q.kind != OP_READ;
				d_re = cmd_q.kind != OP_READ;
			end
			ST_RD3: begin
				d_addr = d_addr_q;
				d_we   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rel_we) begin
			rel_mem[rel_addr] <= {q_cmd.cohort_id, q_cmd.date_months, q_cmd.cell_y, q_cmd.cell_x};
		end
		if (rel_re) begin
			rel_rd_q <= rel_mem[rel_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (bin_we) begin
			bin_mem[bin_addr] <= q_cmd.bin_value;
		end
		if (bin_re) begin
			bin_rd_q <= bin_mem[bin_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			dist_mem[d_addr] <= d_wdata;
		end
		if (d_re) begin
			d_rd_q <= dist_mem[d_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[x_addr] <= x_wdata;
		end
		if (x_re) begin
			x_rd_q <= x_mem[x_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (y_we) begin
			y_mem[y_addr] <= y_wdata;
		end
		if (y_re) begin
			y_rd_q <= y_mem[y_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_CALC) begin
			row_q      <= row_c;
			dxi_q      <= 7'(dx_c + $signed(8'(GRID - 1)));
			dyi_q      <= 7'(dy_c + $signed(8'(GRID - 1)));
			bin_addr_q <= {ax, ay};
		end
		if (state_q == ST_RD2) begin
			d_addr_q <= {row_q, bin_k};
		end
		if (state_q == ST_FIN && emit_q && out_free) begin
			status_q <= res_status_q;
			count_q  <= res_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			cnt_q        <= '0;
			chk_q        <= 1'b0;
			emit_q       <= 1'b0;
			active_q     <= 7'd0;
			out_valid_q  <= 1'b0;
			res_status_q <= STAT_OK;
			res_count_q  <= 32'd0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && !(state_q == ST_FIN && emit_q)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (&cnt_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						emit_q       <= 1'b1;
						res_status_q <= STAT_OK;
						res_count_q  <= 32'd0;
						cnt_q        <= '0;
						chk_q        <= 1'b0;
						unique case (q_cmd.kind)
							OP_CLEAR: state_q <= ST_CLR;
							OP_RECAP: state_q <= ST_SRCH;
							OP_READ:  state_q <= ST_RD1;
							default:  state_q <= ST_FIN;
						endcase
					end
				end
				ST_SRCH: begin
					if (chk_q && match) begin
						state_q <= ST_CALC;
					end else if (cnt_q[6:0] == n_search) begin
						res_status_q <= STAT_NOTFOUND;
						state_q      <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						chk_q <= 1'b1;
					end
				end
				ST_CALC: begin
					res_status_q <= tal[16] ? STAT_NEGTIME : STAT_OK;
					state_q      <= ST_RD1;
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					if (cmd_q.kind == OP_READ) begin
						res_count_q <= cmd_q.read_ok ? read_val : 32'd0;
						state_q     <= ST_FIN;
					end else begin
						state_q <= ST_RD3;
					end
				end
				ST_RD3: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!emit_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/recapture_displacement_histogram.sv
// Top level of the recapture displacement histogram engine.
// Input channel in_valid/in_ready carries one command item: clear, release write,
// bin table write, recapture or histogram read. Output channel out_valid/out_ready
// returns exactly one result item (status, count) per input item, in order.
// The user must write the active_releases register through cfg_we/cfg_wdata
// only while idle; the block does not enforce it. A two-entry queue separates
// the accepting front end from the back end, so items are taken while a result
// waits in the output register. A recapture searches the active release slots,
// at most 64, one per cycle through the release table port. A clear sweeps all
// histogram memories one address per cycle. After reset the same clearing pass
// runs before the first item is taken from the queue; it produces no result.
// When the receiver stalls the result is held in the output register, the back
// end waits, and once the queue is full in_ready drops.
module recapture_displacement_histogram (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [5:0]  slot,
	input  logic [15:0] cohort_id,
	input  logic [15:0] date_months,
	input  logic [5:0]  cell_x,
	input  logic [5:0]  cell_y,
	input  logic [15:0] weight,
	input  logic [5:0]  bin_value,
	input  logic [1:0]  table_select,
	input  logic [4:0]  read_month,
	input  logic [6:0]  read_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] count,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	import rdh_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;

	rdh_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.slot         (slot),
		.cohort_id    (cohort_id),
		.date_months  (date_months),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.weight       (weight),
		.bin_value    (bin_value),
		.table_select (table_select),
		.read_month   (read_month),
		.read_index   (read_index),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (push_cmd)
	);

	rdh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_cmd (head_cmd)
	);

	rdh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_empty   (q_empty),
		.q_cmd     (head_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.count     (count)
	);

endmodule

>>> bench/rdh_checker.sv
// Checker that predicts the histogram engine's results and compares them with its outputs.
module rdh_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  operation,
	input  logic [5:0]  slot,
	input  logic [15:0] cohort_id,
	input  logic [15:0] date_months,
	input  logic [5:0]  cell_x,
	input  logic [5:0]  cell_y,
	input  logic [15:0] weight,
	input  logic [5:0]  bin_value,
	input  logic [1:0]  table_select,
	input  logic [4:0]  read_month,
	input  logic [6:0]  read_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [31:0] count,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	output int          errors
);
	import rdh_pkg::*;

	localparam int OFFS = 2 * GRID - 1;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] count;
	} result_t;

	result_t     pending_results[$];
	logic [15:0] rel_cohort [RELEASES];
	logic [15:0] rel_month [RELEASES];
	logic [5:0]  rel_x [RELEASES];
	logic [5:0]  rel_y [RELEASES];
	logic [5:0]  bin_map [GRID*GRID];
	logic [31:0] dist_hist [MONTHS*DIST_BINS];
	logic [31:0] xoff_hist [MONTHS*OFFS];
	logic [31:0] yoff_hist [MONTHS*OFFS];
	logic [6:0]  active_slots;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [15:0] w);
		logic [32:0] s;
		s = {1'b0, a} + {17'd0, w};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic wipe_hists();
		foreach (dist_hist[i]) dist_hist[i] = '0;
		foreach (xoff_hist[i]) xoff_hist[i] = '0;
		foreach (yoff_hist[i]) yoff_hist[i] = '0;
	endtask

	function automatic result_t tally_recapture();
		result_t r;
		int n, s, found, tal, dx, dy, ax, ay, k, row;
		r = '0;
		n = (active_slots > RELEASES) ? RELEASES : active_slots;
		found = -1;
		for (s = 0; s < n; s++) begin
			if (found < 0 && rel_cohort[s] == cohort_id)
				found = s;
		end
		if (found < 0) begin
			r.status = STAT_NOTFOUND;
			return r;
		end
		r.status = STAT_OK;
		tal = int'(date_months) - int'(rel_month[found]);
		if (tal < 0) begin
			tal = 0;
			r.status = STAT_NEGTIME;
		end
		if (tal > MONTHS - 1)
			tal = MONTHS - 1;
		row = tal;
		dx = int'(cell_x) - int'(rel_x[found]);
		dy = int'(cell_y) - int'(rel_y[found]);
		if (dx > GRID - 1) dx = GRID - 1;
		if (dx < -(GRID - 1)) dx = -(GRID - 1);
		if (dy > GRID - 1) dy = GRID - 1;
		if (dy < -(GRID - 1)) dy = -(GRID - 1);
		xoff_hist[row*OFFS + dx + GRID - 1] = add_sat(xoff_hist[row*OFFS + dx + GRID - 1], weight);
		yoff_hist[row*OFFS + dy + GRID - 1] = add_sat(yoff_hist[row*OFFS + dy + GRID - 1], weight);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		k = bin_map[ax*GRID + ay];
		if (k > DIST_BINS - 1)
			k = DIST_BINS - 1;
		dist_hist[row*DIST_BINS + k] = add_sat(dist_hist[row*DIST_BINS + k], weight);
		return r;
	endfunction

	function automatic logic [31:0] lookup_hist();
		int m, idx;
		m = read_month;
		idx = read_index;
		if (m >= MONTHS)
			return '0;
		case (table_select)
			SEL_DIST: return idx < DIST_BINS ? dist_hist[m*DIST_BINS + idx] : '0;
			SEL_X: return idx < OFFS ? xoff_hist[m*OFFS + idx] : '0;
			SEL_Y: return idx < OFFS ? yoff_hist[m*OFFS + idx] : '0;
			default: return '0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t r, got;
		if (!arst_n) begin
			pending_results.delete();
			foreach (rel_cohort[i]) begin
				rel_cohort[i] = '0;
				rel_month[i] = '0;
				rel_x[i] = '0;
				rel_y[i] = '0;
			end
			foreach (bin_map[i]) bin_map[i] = '0;
			wipe_hists();
			active_slots = '0;
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				got.status = status;
				got.count = count;
				if (pending_results.size() == 0) begin
					$display("unexpected result at %0t: status %0d count %0d", $realtime,
						status, count);
					errors++;
				end else begin
					r = pending_results.pop_front();
					if (got.status !== r.status)
						report("status", got.status, r.status);
					if (got.count !== r.count)
						report("count", got.count, r.count);
				end
			end
			if (in_valid && in_ready) begin
				r = '0;
				case (operation)
					OP_CLEAR: wipe_hists();
					OP_RELEASE: begin
						rel_cohort[slot] = cohort_id;
						rel_month[slot] = date_months;
						rel_x[slot] = cell_x;
						rel_y[slot] = cell_y;
					end
					OP_BIN: bin_map[int'(cell_x)*GRID + int'(cell_y)] = bin_value;
					OP_RECAP: r = tally_recapture();
					OP_READ: r.count = lookup_hist();
					default: ;
				endcase
				pending_results.push_back(r);
			end
			if (cfg_we)
				active_slots = cfg_wdata;
		end
	end

	final begin
		if (pending_results.size() != 0)
			$display("%0d results never arrived", pending_results.size());
	end

endmodule

>>> bench/tb_recapture_displacement_histogram.sv
// Testbench top that drives the histogram engine and reports the verdict.
module tb_recapture_displacement_histogram;
	import rdh_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = '0;
	logic [5:0]  slot = '0;
	logic [15:0] cohort_id = '0;
	logic [15:0] date_months = '0;
	logic [5:0]  cell_x = '0;
	logic [5:0]  cell_y = '0;
	logic [15:0] weight = '0;
	logic [5:0]  bin_value = '0;
	logic [1:0]  table_select = '0;
	logic [4:0]  read_month = '0;
	logic [6:0]  read_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] count;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	int          errors;

	logic [15:0] plan_cohort [RELEASES];
	logic [15:0] plan_month [RELEASES];
	logic [5:0]  plan_x [RELEASES];
	logic [5:0]  plan_y [RELEASES];
	bit          bin_known [GRID*GRID];
	int          plan_active = 0;
	int          burst_left = 0;
	int          n_sent = 0;
	int          n_back = 0;
	int          quiet = 0;
	bit          full_speed = 1'b0;
	int          stall_mode = 0;

	always #10 clk = ~clk;

	recapture_displacement_histogram u_top (.*);

	rdh_checker u_check (.*);

	always @(posedge clk) begin
		if (in_valid && in_ready)
			n_sent <= n_sent + 1;
		if (out_valid && out_ready)
			n_back <= n_back + 1;
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= 30000) begin
			$display("FAIL recapture_displacement_histogram");
			$finish;
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (full_speed ? 0 : stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 15) == 0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send(input logic [2:0] op, input logic [5:0] sl, input logic [15:0] coh,
			input logic [15:0] dt, input logic [5:0] x, input logic [5:0] y,
			input logic [15:0] w, input logic [5:0] bv, input logic [1:0] sel,
			input logic [4:0] rm, input logic [6:0] ri);
		if (!full_speed && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		slot <= sl;
		cohort_id <= coh;
		date_months <= dt;
		cell_x <= x;
		cell_y <= y;
		weight <= w;
		bin_value <= bv;
		table_select <= sel;
		read_month <= rm;
		read_index <= ri;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == OP_RELEASE) begin
			plan_cohort[sl] = coh;
			plan_month[sl] = dt;
			plan_x[sl] = x;
			plan_y[sl] = y;
		end
		if (op == OP_BIN)
			bin_known[int'(x)*GRID + int'(y)] = 1'b1;
	endtask

	task automatic write_release(input logic [5:0] sl, input logic [15:0] coh,
			input logic [15:0] dt, input logic [5:0] x, input logic [5:0] y);
		send(OP_RELEASE, sl, coh, dt, x, y, 16'($urandom), 6'($urandom), 2'($urandom),
			5'($urandom), 7'($urandom));
	endtask

	task automatic write_bin(input logic [5:0] x, input logic [5:0] y, input logic [5:0] bv);
		send(OP_BIN, 6'($urandom), 16'($urandom), 16'($urandom), x, y, 16'($urandom), bv,
			2'($urandom), 5'($urandom), 7'($urandom));
	endtask

	task automatic read_hist(input logic [1:0] sel, input logic [4:0] rm, input logic [6:0] ri);
		send(OP_READ, 6'($urandom), 16'($urandom), 16'($urandom), 6'($urandom), 6'($urandom),
			16'($urandom), 6'($urandom), sel, rm, ri);
	endtask

	// A recapture that would look up an unwritten bin entry gets that entry written first.
	task automatic recapture(input logic [15:0] coh, input logic [15:0] dt,
			input logic [5:0] x, input logic [5:0] y, input logic [15:0] w);
		int n, s, hit, ax, ay;
		n = plan_active > RELEASES ? RELEASES : plan_active;
		hit = -1;
		for (s = 0; s < n; s++) begin
			if (hit < 0 && plan_cohort[s] == coh)
				hit = s;
		end
		if (hit >= 0) begin
			ax = int'(x) - int'(plan_x[hit]);
			ay = int'(y) - int'(plan_y[hit]);
			ax = ax < 0 ? -ax : ax;
			ay = ay < 0 ? -ay : ay;
			if (!bin_known[ax*GRID + ay])
				write_bin(6'(ax), 6'(ay), 6'($urandom));
		end
		send(OP_RECAP, 6'($urandom), coh, dt, x, y, w, 6'($urandom), 2'($urandom),
			5'($urandom), 7'($urandom));
	endtask

	task automatic settle_and_config(input logic [6:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_back != n_sent) @(posedge clk);
		repeat (100) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		plan_active = value;
	endtask

	task automatic random_item();
		int pick, n;
		n = plan_active > RELEASES ? RELEASES : plan_active;
		pick = $urandom_range(0, 99);
		if (pick < 40 && n > 0)
			recapture(plan_cohort[$urandom_range(0, n - 1)], 16'($urandom), 6'($urandom),
				6'($urandom), 16'($urandom));
		else if (pick < 48)
			recapture(16'($urandom), 16'($urandom), 6'($urandom), 6'($urandom),
				16'($urandom));
		else if (pick < 70)
			read_hist(2'($urandom), 5'($urandom), ($urandom_range(0, 3) == 0) ? 7'($urandom)
				: 7'($urandom_range(0, 70)));
		else if (pick < 80)
			write_release(6'($urandom), 16'($urandom_range(0, 7)), 16'($urandom),
				6'($urandom), 6'($urandom));
		else if (pick < 92)
			write_bin(6'($urandom), 6'($urandom), 6'($urandom));
		else if (pick < 95)
			send(OP_CLEAR, 6'($urandom), 16'($urandom), 16'($urandom), 6'($urandom),
				6'($urandom), 16'($urandom), 6'($urandom), 2'($urandom), 5'($urandom),
				7'($urandom));
		else
			send(3'($urandom_range(5, 7)), 6'($urandom), 16'($urandom), 16'($urandom),
				6'($urandom), 6'($urandom), 16'($urandom), 6'($urandom), 2'($urandom),
				5'($urandom), 7'($urandom));
	endtask

	initial begin
		logic [6:0] settings [5];
		settings = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd37};
		foreach (bin_known[i]) bin_known[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		settle_and_config(7'd4);

		for (int s = 0; s < RELEASES; s++)
			write_release(6'(s), 16'(s[2:0]), 16'(100 + s), 6'(s), 6'(s));
		write_release(6'd1, 16'hFFFF, 16'hFFFF, 6'd63, 6'd63);
		write_bin(6'd0, 6'd0, 6'd63);
		write_bin(6'd63, 6'd63, 6'd0);
		recapture(16'd0, 16'd100, 6'd0, 6'd0, 16'd0);
		recapture(16'd0, 16'd50, 6'd63, 6'd0, 16'hFFFF);
		recapture(16'd0, 16'hFFFF, 6'd0, 6'd63, 16'd7);
		recapture(16'hFFFF, 16'hFFFF, 6'd0, 6'd0, 16'hFFFF);
		recapture(16'hFFFF, 16'd0, 6'd63, 6'd63, 16'd1);
		recapture(16'h1234, 16'd200, 6'd5, 6'd5, 16'd9);
		read_hist(SEL_DIST, 5'd0, 7'd63);
		read_hist(SEL_X, 5'd31, 7'd126);
		read_hist(SEL_Y, 5'd0, 7'd0);
		read_hist(SEL_X, 5'd0, 7'd127);
		read_hist(SEL_DIST, 5'd31, 7'd64);
		read_hist(2'd3, 5'd0, 7'd0);
		send(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
		read_hist(SEL_DIST, 5'd0, 7'd63);
		for (int op = 5; op < 8; op++)
			send(3'(op), '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);

		foreach (settings[p]) begin
			settle_and_config(p == 4 ? 7'($urandom_range(2, 127)) : settings[p]);
			repeat (120) random_item();
		end

		// Back-to-back items with the receiver always ready.
		full_speed = 1'b1;
		repeat (30) random_item();
		full_speed = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (n_back != n_sent) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS recapture_displacement_histogram");
		else
			$display("FAIL recapture_displacement_histogram");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/rdh_pkg.sv
hw/rtl/rdh_front.sv
hw/rtl/rdh_queue.sv
hw/rtl/rdh_back.sv
hw/rtl/recapture_displacement_histogram.sv
bench/rdh_checker.sv
bench/tb_recapture_displacement_histogram.sv
